// ----- hw/rtl/paged_translation_lru_replace_assert.svh -----
// Assertion macros shared by the paged translation block.
// Each expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef PAGED_TRANSLATION_LRU_REPLACE_ASSERT_SVH
`define PAGED_TRANSLATION_LRU_REPLACE_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define PTLRU_ASSERT_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define PTLRU_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PTLRU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/ptlru_pkg.sv -----
// Shared types and constants for the paged translation block.
// No dependencies.
package ptlru_pkg;

	localparam int PAGE_W   = 6;
	localparam int FRAME_W  = 6;
	localparam int BLOCK_W  = 16;
	localparam int ADDR_W   = 16;
	localparam int PCNT_W   = 7;

	localparam int PAGES_DEF       = 64;
	localparam int FRAMES_DEF      = 16;
	localparam int OFFSET_BITS_DEF = 10;

	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_FRAME  = 2'd1,
		KIND_ACCESS = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NO_PAGE   = 2'd1,
		STATUS_NO_FRAME  = 2'd2,
		STATUS_LIST_FULL = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Recency list cell operations
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_APPEND,   // write page at the tail slot
		CELL_EVICT,    // shift whole row down, page enters at the head
		CELL_PROMOTE   // shift down up to the matching slot, page enters at the head
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [PAGE_W-1:0]   page;
	} cell_ctl_t;

endpackage

// ----- hw/rtl/ptlru_ram.sv -----
// Generic RAM: one write port, two registered read ports sharing a read enable.
// No dependencies.
module ptlru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [AW-1:0]            raddr_a,
	input  logic [AW-1:0]            raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_a_q <= mem_q[raddr_a];
			rd_b_q <= mem_q[raddr_b];
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

// ----- hw/rtl/ptlru_cell.sv -----
// One slot of the recency list; slots chain head to tail.
// Depends on ptlru_pkg.
module ptlru_cell #(
	parameter int RC_W = 5,
	parameter int IDX  = 0
) (
	input  logic                         clk,
	input  ptlru_pkg::cell_ctl_t         ctl,
	input  logic [RC_W-1:0]              rc,
	input  logic [ptlru_pkg::PAGE_W-1:0] left,
	input  logic                         seen_in,
	output logic [ptlru_pkg::PAGE_W-1:0] value,
	output logic                         seen_out
);

	logic [ptlru_pkg::PAGE_W-1:0] value_q;
	logic [ptlru_pkg::PAGE_W-1:0] value_d;
	logic                         match;

	assign match    = (value_q == ctl.page);
	// a slot nearer the head already holds the page: keep this one
	assign seen_out = seen_in | match;

	always_comb begin
		value_d = value_q;
		case (ctl.op)
			ptlru_pkg::CELL_APPEND: begin
				if (rc == RC_W'(IDX)) begin
					value_d = ctl.page;
				end
			end
			ptlru_pkg::CELL_EVICT: begin
				value_d = left;
			end
			ptlru_pkg::CELL_PROMOTE: begin
				if (!seen_in) begin
					value_d = left;
				end
			end
			default: begin
				value_d = value_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;

endmodule

// ----- hw/rtl/paged_translation_lru_replace.sv -----
// IDLE takes an item and reads the page table RAMs; EXEC updates flags, RAMs and the
// recency cell row, and loads the registered result. No new item is taken until EXEC
// completes; a stalled result holds the block in EXEC until the transfer out.
// Reset (arst_n, async): clears page_count, resident and dirty flags, resident count,
// FSM and result valid; page table RAMs and the list come up undefined, no clearing pass.
module paged_translation_lru_replace #(
	parameter int PAGES       = ptlru_pkg::PAGES_DEF,
	parameter int FRAMES      = ptlru_pkg::FRAMES_DEF,
	parameter int OFFSET_BITS = ptlru_pkg::OFFSET_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [ptlru_pkg::PCNT_W-1:0]  cfg_wdata,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    kind,
	input  logic [ptlru_pkg::PAGE_W-1:0]  page_index,
	input  logic [ptlru_pkg::BLOCK_W-1:0] disk_block,
	input  logic [ptlru_pkg::FRAME_W-1:0] frame_number,
	input  logic [ptlru_pkg::ADDR_W-1:0]  logical_address,
	input  logic                          is_write,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [ptlru_pkg::ADDR_W-1:0]  physical_address,
	output logic                          page_fault,
	output logic [ptlru_pkg::PAGE_W-1:0]  evicted_page,
	output logic                          write_back,
	output logic [ptlru_pkg::BLOCK_W-1:0] write_back_block,
	output logic [ptlru_pkg::BLOCK_W-1:0] fetch_block
);

	`include "paged_translation_lru_replace_assert.svh"

	localparam int PIDX_W = $clog2(PAGES);
	localparam int RC_W   = $clog2(FRAMES + 1);
	localparam int LIST_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int PAGE_W = ptlru_pkg::PAGE_W;
	localparam int ADDR_W = ptlru_pkg::ADDR_W;
	localparam int BLK_W  = ptlru_pkg::BLOCK_W;
	localparam int FRM_W  = ptlru_pkg::FRAME_W;
	localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'((33'd1 << OFFSET_BITS) - 33'd1);

	// ---------------------------------------------------------------
	// Control state
	// ---------------------------------------------------------------
	ptlru_pkg::state_t state_q, state_d;
	logic take;      // input transfer
	logic commit;    // EXEC completes: state and result update

	logic [ptlru_pkg::PCNT_W-1:0] page_count_q;
	logic [PAGES-1:0]             resident_q, resident_d;
	logic [PAGES-1:0]             dirty_q, dirty_d;
	logic [RC_W-1:0]              rc_q, rc_d;

	// captured item
	logic [1:0]           kind_q;
	logic [PAGE_W-1:0]    pidx_q;
	logic [BLK_W-1:0]     dblk_q;
	logic [FRM_W-1:0]     frm_q;
	logic [ADDR_W-1:0]    offset_q;
	logic [PAGE_W-1:0]    page_q;
	logic                 page_bad_q;
	logic                 wr_q;
	logic [PAGE_W-1:0]    victim_q;

	// result register
	logic                 out_valid_q;
	ptlru_pkg::status_t   status_q, status_d;
	logic [ADDR_W-1:0]    pa_q, pa_d;
	logic                 pf_q, pf_d;
	logic [PAGE_W-1:0]    ev_q, ev_d;
	logic                 wb_q, wb_d;
	logic [BLK_W-1:0]     wbb_q, wbb_d;
	logic [BLK_W-1:0]     fb_q, fb_d;

	// page split on the way in; out-of-range pages are flagged before truncation
	logic [ADDR_W-1:0]    page_full;
	logic                 page_bad;
	logic [PAGE_W-1:0]    victim;

	// RAM hookup
	logic                 frm_we, blk_we;
	logic [PIDX_W-1:0]    frm_waddr, blk_waddr;
	logic [FRM_W-1:0]     frm_wdata;
	logic [FRM_W-1:0]     frm_rd_page, frm_rd_victim;
	logic [BLK_W-1:0]     blk_rd_page, blk_rd_victim;

	// recency list row
	ptlru_pkg::cell_ctl_t  cell_ctl;
	logic [PAGE_W-1:0]     cell_val [FRAMES];
	logic                  cell_seen [FRAMES+1];

	// ---------------------------------------------------------------
	// FSM: IDLE takes an item, EXEC finishes it once the result slot is free
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ptlru_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = ptlru_pkg::ST_EXEC;
				end
			end
			ptlru_pkg::ST_EXEC: begin
				if (!out_valid_q || out_ready) begin
					state_d = ptlru_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ptlru_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		commit   = 1'b0;
		case (state_q)
			ptlru_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			ptlru_pkg::ST_EXEC: begin
				commit = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptlru_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------------------------------------------------------
	// IDLE: split address, pick victim from list tail, launch RAM reads
	// ---------------------------------------------------------------
	assign page_full = ADDR_W'(logical_address >> OFFSET_BITS);
	assign page_bad  = (32'(page_full) >= PAGES) || (32'(page_full) >= 32'(page_count_q));
	assign victim    = cell_val[LIST_W'(rc_q - RC_W'(1))];

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q     <= kind;
			pidx_q     <= page_index;
			dblk_q     <= disk_block;
			frm_q      <= frame_number;
			offset_q   <= logical_address & OFF_MASK;
			page_q     <= PAGE_W'(page_full);
			page_bad_q <= page_bad;
			wr_q       <= is_write;
			victim_q   <= victim;
		end
	end

	ptlru_ram #(
		.WIDTH (FRM_W),
		.DEPTH (PAGES)
	) u_frame_ram (
		.clk     (clk),
		.we      (frm_we),
		.waddr   (frm_waddr),
		.wdata   (frm_wdata),
		.re      (take),
		.raddr_a (PIDX_W'(page_full)),
		.raddr_b (PIDX_W'(victim)),
		.rdata_a (frm_rd_page),
		.rdata_b (frm_rd_victim)
	);

	ptlru_ram #(
		.WIDTH (BLK_W),
		.DEPTH (PAGES)
	) u_block_ram (
		.clk     (clk),
		.we      (blk_we),
		.waddr   (blk_waddr),
		.wdata   (dblk_q),
		.re      (take),
		.raddr_a (PIDX_W'(page_full)),
		.raddr_b (PIDX_W'(victim)),
		.rdata_a (blk_rd_page),
		.rdata_b (blk_rd_victim)
	);

	// ---------------------------------------------------------------
	// EXEC: decide, update tables and list, form the result
	// ---------------------------------------------------------------
	always_comb begin
		logic [PIDX_W-1:0] pg;
		logic [PIDX_W-1:0] vc;
		logic [PIDX_W-1:0] nx;
		logic              hit;

		pg  = PIDX_W'(page_q);
		vc  = PIDX_W'(victim_q);
		nx  = PIDX_W'(rc_q);
		hit = resident_q[pg];

		status_d   = ptlru_pkg::STATUS_OK;
		pa_d       = '0;
		pf_d       = 1'b0;
		ev_d       = '0;
		wb_d       = 1'b0;
		wbb_d      = '0;
		fb_d       = '0;
		resident_d = resident_q;
		dirty_d    = dirty_q;
		rc_d       = rc_q;
		frm_we     = 1'b0;
		frm_waddr  = pg;
		frm_wdata  = frm_rd_victim;
		blk_we     = 1'b0;
		blk_waddr  = PIDX_W'(pidx_q);
		cell_ctl.op   = ptlru_pkg::CELL_HOLD;
		cell_ctl.page = page_q;

		case (kind_q)
			ptlru_pkg::KIND_LOAD: begin
				if (32'(pidx_q) < PAGES) begin
					blk_we = 1'b1;
				end else begin
					status_d = ptlru_pkg::STATUS_NO_PAGE;
				end
			end
			ptlru_pkg::KIND_FRAME: begin
				if (32'(rc_q) >= FRAMES) begin
					status_d = ptlru_pkg::STATUS_LIST_FULL;
				end else if (32'(rc_q) >= PAGES || 32'(rc_q) >= 32'(page_count_q)) begin
					status_d = ptlru_pkg::STATUS_NO_PAGE;
				end else if (!resident_q[nx]) begin
					// next page in order joins at the list tail
					frm_we         = 1'b1;
					frm_waddr      = nx;
					frm_wdata      = frm_q;
					resident_d[nx] = 1'b1;
					dirty_d[nx]    = 1'b0;
					rc_d           = rc_q + RC_W'(1);
					cell_ctl.op    = ptlru_pkg::CELL_APPEND;
					cell_ctl.page  = PAGE_W'(rc_q);
				end
			end
			ptlru_pkg::KIND_ACCESS: begin
				if (page_bad_q) begin
					status_d = ptlru_pkg::STATUS_NO_PAGE;
				end else if (!hit && rc_q == '0) begin
					status_d = ptlru_pkg::STATUS_NO_FRAME;
				end else if (!hit) begin
					// miss: tail page gives up its frame, new page enters at the head
					pf_d  = 1'b1;
					ev_d  = victim_q;
					wb_d  = dirty_q[vc];
					wbb_d = dirty_q[vc] ? blk_rd_victim : '0;
					fb_d  = blk_rd_page;
					resident_d[vc] = 1'b0;
					dirty_d[vc]    = 1'b0;
					resident_d[pg] = 1'b1;
					dirty_d[pg]    = wr_q;
					frm_we         = 1'b1;
					frm_wdata      = frm_rd_victim;
					cell_ctl.op    = ptlru_pkg::CELL_EVICT;
					pa_d = ADDR_W'(32'(frm_rd_victim) << OFFSET_BITS) | offset_q;
				end else begin
					// hit: promote to the head
					dirty_d[pg] = dirty_q[pg] | wr_q;
					cell_ctl.op = ptlru_pkg::CELL_PROMOTE;
					pa_d = ADDR_W'(32'(frm_rd_page) << OFFSET_BITS) | offset_q;
				end
			end
			default: begin
				status_d = ptlru_pkg::STATUS_OK;
			end
		endcase

		if (!commit) begin
			frm_we      = 1'b0;
			blk_we      = 1'b0;
			cell_ctl.op = ptlru_pkg::CELL_HOLD;
		end
	end

	// ---------------------------------------------------------------
	// Recency list: head at cell 0, each cell takes from its left neighbour
	// ---------------------------------------------------------------
	assign cell_seen[0] = 1'b0;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		logic [PAGE_W-1:0] left;
		if (i == 0) begin : g_head
			assign left = cell_ctl.page;
		end else begin : g_body
			assign left = cell_val[i-1];
		end
		ptlru_cell #(
			.RC_W (RC_W),
			.IDX  (i)
		) u_cell (
			.clk      (clk),
			.ctl      (cell_ctl),
			.rc       (rc_q),
			.left     (left),
			.seen_in  (cell_seen[i]),
			.value    (cell_val[i]),
			.seen_out (cell_seen[i+1])
		);
	end

	// ---------------------------------------------------------------
	// State registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q <= '0;
			resident_q   <= '0;
			dirty_q      <= '0;
			rc_q         <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				page_count_q <= cfg_wdata;
			end
			if (commit) begin
				resident_q  <= resident_d;
				dirty_q     <= dirty_d;
				rc_q        <= rc_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= status_d;
			pa_q     <= pa_d;
			pf_q     <= pf_d;
			ev_q     <= ev_d;
			wb_q     <= wb_d;
			wbb_q    <= wbb_d;
			fb_q     <= fb_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign physical_address = pa_q;
	assign page_fault       = pf_q;
	assign evicted_page     = ev_q;
	assign write_back       = wb_q;
	assign write_back_block = wbb_q;
	assign fetch_block      = fb_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`PTLRU_ASSERT_HOLDS(a_rc_bound, 32'(rc_q) <= FRAMES, "resident count above frame count")
	`PTLRU_ASSERT_HOLDS(a_rc_flags, $countones(resident_q) == 32'(rc_q), "flags disagree with count")
	`PTLRU_ASSERT_HOLDS(a_dirty_res, (dirty_q & ~resident_q) == '0, "dirty page not resident")
	`PTLRU_ASSERT_NEXT(a_commit_out, commit, out_valid_q && state_q == ptlru_pkg::ST_IDLE, "result lost")
	`PTLRU_ASSERT_IMPL(a_fault_ok, out_valid && page_fault, status == 2'(ptlru_pkg::STATUS_OK), "fault with error")

endmodule
